// ===== hdl/rcsn_pkg.sv =====
`default_nettype none

package rcsn_pkg;

  // Field and register widths.
  localparam int PULSE_W     = 16;
  localparam int NORM_W      = 16;
  localparam int THR_NORM_W  = 15;
  localparam int DEADBAND_W  = 9;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 9;

  // Internal magnitude widths.
  localparam int STICK_MAG_W = 10;   // |p - 1500| for a plausible pulse, at most 600
  localparam int THR_MAG_W   = 11;   // p - 1000 for a plausible pulse, at most 1100
  localparam int Q_W         = 15;   // Q2.14 magnitude, 0..19660 before clamping

  // Pipeline depth from input register to output register.
  localparam int NUM_STAGES = 5;

  // Pulse limits in microseconds.
  localparam logic [PULSE_W-1:0] PULSE_MIN    = 16'd900;
  localparam logic [PULSE_W-1:0] PULSE_MAX    = 16'd2100;
  localparam logic [PULSE_W-1:0] STICK_CENTRE = 16'd1500;
  localparam logic [PULSE_W-1:0] THR_BASE     = 16'd1000;

  // Q2.14 full scale.
  localparam logic [Q_W-1:0] Q_ONE = 15'd16384;
  localparam logic signed [NORM_W-1:0] NORM_MAX = 16'sd16384;
  localparam logic signed [NORM_W-1:0] NORM_MIN = -16'sd16384;

  // Reciprocal scaling: floor(m * 4096 / 125) and floor(t * 2048 / 125) are
  // taken as (x * RECIP) >> RECIP_SHIFT. The rounding-up error of each
  // reciprocal stays below 1/125 over the whole input range, so the floor
  // is exact.
  localparam int RECIP_SHIFT    = 20;
  localparam int STICK_RECIP_W  = 26;
  localparam int THR_RECIP_W    = 25;
  localparam logic [STICK_RECIP_W-1:0] STICK_RECIP = 26'd34359739;
  localparam logic [THR_RECIP_W-1:0]   THR_RECIP   = 25'd17179870;

  // Cubic expo: x^3 / 2^28 in Q2.14.
  localparam int CUBE_SHIFT = 28;

  // Reset values of the configuration registers.
  localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 9'd10;
  localparam logic                  CUBIC_RESET    = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DEADBAND_US = 4'd0,
    CFG_SHAPE_MODE  = 4'd1
  } cfg_index_t;

  // Live configuration seen by the lanes.
  typedef struct packed {
    logic [DEADBAND_W-1:0] deadband_us;
    logic                  cubic;
  } cfg_t;

  // Per-stage load enables from the pipeline control.
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } stage_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/rcsn_if.sv =====
`default_nettype none

// Request channel carrying one frame of four pulse widths.
interface rcsn_pulse_if;
  logic                            valid;
  logic                            ready;
  logic [rcsn_pkg::PULSE_W-1:0]    roll_pulse;
  logic [rcsn_pkg::PULSE_W-1:0]    pitch_pulse;
  logic [rcsn_pkg::PULSE_W-1:0]    throttle_pulse;
  logic [rcsn_pkg::PULSE_W-1:0]    yaw_pulse;

  modport source (output valid, output roll_pulse, output pitch_pulse,
                  output throttle_pulse, output yaw_pulse, input ready);
  modport sink   (input valid, input roll_pulse, input pitch_pulse,
                  input throttle_pulse, input yaw_pulse, output ready);
endinterface

// Request channel carrying one frame of normalised stick values.
interface rcsn_norm_if;
  logic                                valid;
  logic                                ready;
  logic signed [rcsn_pkg::NORM_W-1:0]  roll_norm;
  logic signed [rcsn_pkg::NORM_W-1:0]  pitch_norm;
  logic [rcsn_pkg::THR_NORM_W-1:0]     throttle_norm;
  logic signed [rcsn_pkg::NORM_W-1:0]  yaw_norm;

  modport source (output valid, output roll_norm, output pitch_norm,
                  output throttle_norm, output yaw_norm, input ready);
  modport sink   (input valid, input roll_norm, input pitch_norm,
                  input throttle_norm, input yaw_norm, output ready);
endinterface

// Configuration write channel.
interface rcsn_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rcsn_pkg::CFG_INDEX_W-1:0]  index;
  logic [rcsn_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/rcsn_stick_lane.sv =====
`default_nettype none

// One roll, pitch or yaw lane: range check and deadband, reciprocal scale,
// clamp, square, cube and sign. Five register stages.
module rcsn_stick_lane (
  input  wire logic                               clk,
  input  wire rcsn_pkg::stage_ctrl_t              ctrl,
  input  wire rcsn_pkg::cfg_t                     cfg,
  input  wire logic [rcsn_pkg::PULSE_W-1:0]       pulse,
  output logic signed [rcsn_pkg::NORM_W-1:0]      norm
);

  localparam int PROD_W = rcsn_pkg::STICK_MAG_W + rcsn_pkg::STICK_RECIP_W;
  localparam int SQ_W   = 2 * rcsn_pkg::Q_W;
  localparam int CUBE_W = 3 * rcsn_pkg::Q_W;

  logic                               in_range;
  logic                               below;
  logic [rcsn_pkg::PULSE_W-1:0]       mag_full;
  logic                               in_band;

  logic [rcsn_pkg::STICK_MAG_W-1:0]   s1_mag;
  logic                               s1_neg;
  logic                               s1_zero;

  logic [PROD_W-1:0]                  prod;
  logic [rcsn_pkg::Q_W-1:0]           s2_q;
  logic                               s2_neg;
  logic                               s2_zero;

  logic [rcsn_pkg::Q_W-1:0]           s3_mag;
  logic                               s3_neg;

  logic [SQ_W-1:0]                    sq;
  logic [SQ_W-1:0]                    s4_sq;
  logic [rcsn_pkg::Q_W-1:0]           s4_mag;
  logic                               s4_neg;

  logic [CUBE_W-1:0]                  cube;
  logic [rcsn_pkg::Q_W-1:0]           shaped;
  logic [rcsn_pkg::NORM_W-1:0]        mag_ext;

  // Stage 1: plausibility, distance from centre and deadband.
  always_comb begin
    in_range = (pulse >= rcsn_pkg::PULSE_MIN) && (pulse <= rcsn_pkg::PULSE_MAX);
    below    = pulse < rcsn_pkg::STICK_CENTRE;
    mag_full = below ? (rcsn_pkg::STICK_CENTRE - pulse) : (pulse - rcsn_pkg::STICK_CENTRE);
    in_band  = mag_full <= {{(rcsn_pkg::PULSE_W - rcsn_pkg::DEADBAND_W){1'b0}},
                            cfg.deadband_us};
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      s1_mag  <= mag_full[rcsn_pkg::STICK_MAG_W-1:0];
      s1_neg  <= below;
      s1_zero <= !in_range || in_band;
    end
  end

  // Stage 2: scale by 16384/500 through the reciprocal.
  assign prod = s1_mag * rcsn_pkg::STICK_RECIP;

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      s2_q    <= prod[rcsn_pkg::RECIP_SHIFT + rcsn_pkg::Q_W - 1 : rcsn_pkg::RECIP_SHIFT];
      s2_neg  <= s1_neg;
      s2_zero <= s1_zero;
    end
  end

  // Stage 3: clamp to full scale and apply the zero cases.
  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      if (s2_zero) begin
        s3_mag <= '0;
      end else if (s2_q > rcsn_pkg::Q_ONE) begin
        s3_mag <= rcsn_pkg::Q_ONE;
      end else begin
        s3_mag <= s2_q;
      end
      s3_neg <= s2_neg;
    end
  end

  // Stage 4: square of the magnitude.
  assign sq = s3_mag * s3_mag;

  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      s4_sq  <= sq;
      s4_mag <= s3_mag;
      s4_neg <= s3_neg;
    end
  end

  // Stage 5: cube, shape select and sign.
  always_comb begin
    cube    = s4_sq * s4_mag;
    shaped  = cfg.cubic ?
              cube[rcsn_pkg::CUBE_SHIFT + rcsn_pkg::Q_W - 1 : rcsn_pkg::CUBE_SHIFT] : s4_mag;
    mag_ext = {1'b0, shaped};
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[4]) begin
      norm <= s4_neg ? -mag_ext : mag_ext;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rcsn_thr_lane.sv =====
`default_nettype none

// Throttle lane: range check, offset from the base, reciprocal scale and
// clamp, then two delay stages so that it lines up with the stick lanes.
module rcsn_thr_lane (
  input  wire logic                               clk,
  input  wire rcsn_pkg::stage_ctrl_t              ctrl,
  input  wire logic [rcsn_pkg::PULSE_W-1:0]       pulse,
  output logic [rcsn_pkg::THR_NORM_W-1:0]         norm
);

  localparam int PROD_W = rcsn_pkg::THR_MAG_W + rcsn_pkg::THR_RECIP_W;

  logic                               in_range;
  logic                               below_base;
  logic [rcsn_pkg::PULSE_W-1:0]       offset;

  logic [rcsn_pkg::THR_MAG_W-1:0]     s1_t;
  logic                               s1_zero;

  logic [PROD_W-1:0]                  prod;
  logic [rcsn_pkg::Q_W-1:0]           s2_q;
  logic                               s2_zero;

  logic [rcsn_pkg::Q_W-1:0]           s3_val;
  logic [rcsn_pkg::Q_W-1:0]           s4_val;

  // Stage 1: plausibility and offset from 1000 us; below that is minimum.
  always_comb begin
    in_range   = (pulse >= rcsn_pkg::PULSE_MIN) && (pulse <= rcsn_pkg::PULSE_MAX);
    below_base = pulse < rcsn_pkg::THR_BASE;
    offset     = pulse - rcsn_pkg::THR_BASE;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      s1_t    <= offset[rcsn_pkg::THR_MAG_W-1:0];
      s1_zero <= !in_range || below_base;
    end
  end

  // Stage 2: scale by 16384/1000 through the reciprocal.
  assign prod = s1_t * rcsn_pkg::THR_RECIP;

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      s2_q    <= prod[rcsn_pkg::RECIP_SHIFT + rcsn_pkg::Q_W - 1 : rcsn_pkg::RECIP_SHIFT];
      s2_zero <= s1_zero;
    end
  end

  // Stage 3: clamp to full scale.
  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      if (s2_zero) begin
        s3_val <= '0;
      end else if (s2_q > rcsn_pkg::Q_ONE) begin
        s3_val <= rcsn_pkg::Q_ONE;
      end else begin
        s3_val <= s2_q;
      end
    end
  end

  // Stages 4 and 5: delay to match the cube path.
  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      s4_val <= s3_val;
    end
    if (ctrl.load[4]) begin
      norm <= s4_val;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rc_stick_normalizer.sv =====
// RC stick normaliser.
// Channel pulses (sink): one request carries the roll, pitch, throttle and
// yaw pulse widths in microseconds. Channel sticks (source): one request per
// frame with roll, pitch and yaw in signed Q2.14 and throttle in unsigned
// Q2.14, where 16384 is full deflection. A request moves when valid and
// ready are both high at a rising clock edge.
// Channel cfg (sink): register writes, index 0 is the deadband half width in
// microseconds, index 1 the shape mode (1 = cubic expo on roll, pitch, yaw).
// Other indexes are ignored. cfg is always ready; write it only while no
// frame is in flight.
// A request accepted at a rising edge is held in the first of five register
// stages and passes through the other four in order before it appears on
// sticks. One frame is accepted per cycle unless a stalled receiver has filled
// the pipeline; the rate is set by the five-stage lane pipeline (range check,
// reciprocal multiply, clamp, square, cube), where every stage holds one frame.
// Each stage holds when its successor is full and stalled, so a stalled
// receiver fills the bubbles before pulses.ready drops; nothing is lost.
// Synchronous reset empties the pipeline and sets the deadband to 10 us and
// the shape mode to cubic.
`default_nettype none

module rc_stick_normalizer (
  input  wire logic          clk,
  input  wire logic          rst,
  rcsn_pulse_if.sink         pulses,
  rcsn_norm_if.source        sticks,
  rcsn_cfg_if.sink           cfg
);

  localparam int N = rcsn_pkg::NUM_STAGES;

  logic [N-1:0]            valid;
  logic [N-1:0]            stage_ready;
  rcsn_pkg::stage_ctrl_t   ctrl;
  rcsn_pkg::cfg_t          cfg_regs;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.deadband_us <= rcsn_pkg::DEADBAND_RESET;
      cfg_regs.cubic       <= rcsn_pkg::CUBIC_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        rcsn_pkg::CFG_DEADBAND_US: cfg_regs.deadband_us <= cfg.data[rcsn_pkg::DEADBAND_W-1:0];
        rcsn_pkg::CFG_SHAPE_MODE:  cfg_regs.cubic       <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Stage ready chain: a stage loads when it is empty or its successor moves.
  always_comb begin
    stage_ready[N-1] = !valid[N-1] || sticks.ready;
    for (int k = N - 2; k >= 0; k--) begin
      stage_ready[k] = !valid[k] || stage_ready[k+1];
    end
    ctrl.load = stage_ready;
  end

  assign pulses.ready = stage_ready[0];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (stage_ready[0]) begin
        valid[0] <= pulses.valid;
      end
      for (int k = 1; k < N; k++) begin
        if (stage_ready[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  assign sticks.valid = valid[N-1];

  // Lanes.
  rcsn_stick_lane u_roll (
    .clk   (clk),
    .ctrl  (ctrl),
    .cfg   (cfg_regs),
    .pulse (pulses.roll_pulse),
    .norm  (sticks.roll_norm)
  );

  rcsn_stick_lane u_pitch (
    .clk   (clk),
    .ctrl  (ctrl),
    .cfg   (cfg_regs),
    .pulse (pulses.pitch_pulse),
    .norm  (sticks.pitch_norm)
  );

  rcsn_thr_lane u_throttle (
    .clk   (clk),
    .ctrl  (ctrl),
    .pulse (pulses.throttle_pulse),
    .norm  (sticks.throttle_norm)
  );

  rcsn_stick_lane u_yaw (
    .clk   (clk),
    .ctrl  (ctrl),
    .cfg   (cfg_regs),
    .pulse (pulses.yaw_pulse),
    .norm  (sticks.yaw_norm)
  );

  // A receiver that is ready lets the whole pipeline move, so input is open.
  a_ready_through: assert property (@(posedge clk) disable iff (rst)
    sticks.ready |-> pulses.ready)
    else $error("pipeline blocked input while the output was ready");

  // An empty pipeline with no new request cannot produce a result.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    (valid == '0 && !(pulses.valid && pulses.ready)) |=> !sticks.valid)
    else $error("result produced from an empty pipeline");

  // Throttle never exceeds full scale.
  a_thr_range: assert property (@(posedge clk) disable iff (rst)
    sticks.valid |-> (sticks.throttle_norm <= rcsn_pkg::Q_ONE))
    else $error("throttle beyond full scale");

  // Roll and yaw outputs stay within plus or minus full scale.
  a_stick_range: assert property (@(posedge clk) disable iff (rst)
    sticks.valid |-> (sticks.roll_norm >= rcsn_pkg::NORM_MIN &&
                      sticks.roll_norm <= rcsn_pkg::NORM_MAX &&
                      sticks.yaw_norm >= rcsn_pkg::NORM_MIN &&
                      sticks.yaw_norm <= rcsn_pkg::NORM_MAX))
    else $error("stick output beyond full scale");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rcsn_pkg::*;

  // Scaling spans in microseconds and the Q2.14 full-scale value.
  localparam int STICK_SPAN_US = 500;
  localparam int THR_SPAN_US   = 1000;
  localparam int Q14_ONE       = 16384;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_FRAMES  = 200;

  typedef struct packed {
    logic [PULSE_W-1:0] roll;
    logic [PULSE_W-1:0] pitch;
    logic [PULSE_W-1:0] throttle;
    logic [PULSE_W-1:0] yaw;
  } pulse_frame_t;

  typedef struct packed {
    logic [NORM_W-1:0]     roll;
    logic [NORM_W-1:0]     pitch;
    logic [THR_NORM_W-1:0] throttle;
    logic [NORM_W-1:0]     yaw;
  } stick_frame_t;

  // Holds its own copy of the registers and the stick frames still owed by the block.
  class stick_scoreboard;
    logic [DEADBAND_W-1:0] deadband;
    logic                  cubic;
    stick_frame_t          owed_sticks[$];
    int                    mismatches;
    int                    results_seen;

    function new();
      deadband     = DEADBAND_RESET;
      cubic        = CUBIC_RESET;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        CFG_DEADBAND_US: deadband = data[DEADBAND_W-1:0];
        CFG_SHAPE_MODE:  cubic = data[0];
        default: ;
      endcase
    endfunction

    // Roll, pitch and yaw: range check, deadband, linear map, clamp, then optional cube.
    function longint stick_value(logic [PULSE_W-1:0] pulse);
      longint p;
      longint db;
      longint v;
      longint m;
      p  = pulse;
      db = deadband;
      if (p < longint'(PULSE_MIN) || p > longint'(PULSE_MAX))
        return 0;
      if (p > longint'(STICK_CENTRE) + db || p < longint'(STICK_CENTRE) - db)
        v = ((p - longint'(STICK_CENTRE)) * Q14_ONE) / STICK_SPAN_US;
      else
        v = 0;
      if (v > Q14_ONE) v = Q14_ONE;
      if (v < -Q14_ONE) v = -Q14_ONE;
      if (cubic) begin
        m = (v < 0) ? -v : v;
        m = (m * m * m) >> CUBE_SHIFT;
        v = (v < 0) ? -m : m;
      end
      return v;
    endfunction

    function longint throttle_value(logic [PULSE_W-1:0] pulse);
      longint p;
      longint v;
      p = pulse;
      if (p < longint'(PULSE_MIN) || p > longint'(PULSE_MAX))
        return 0;
      v = ((p - longint'(THR_BASE)) * Q14_ONE) / THR_SPAN_US;
      if (v < 0) v = 0;
      if (v > Q14_ONE) v = Q14_ONE;
      return v;
    endfunction

    function void note_frame(pulse_frame_t f);
      stick_frame_t want;
      longint v;
      v = stick_value(f.roll);
      want.roll = v[NORM_W-1:0];
      v = stick_value(f.pitch);
      want.pitch = v[NORM_W-1:0];
      v = throttle_value(f.throttle);
      want.throttle = v[THR_NORM_W-1:0];
      v = stick_value(f.yaw);
      want.yaw = v[NORM_W-1:0];
      owed_sticks.push_back(want);
    endfunction

    function void compare(string field, int want, int got);
      if (want != got) begin
        if (mismatches < 10)
          $display("Mismatch on %s in stick frame %0d: expected %0d, got %0d",
                   field, results_seen, want, got);
        mismatches++;
      end
    endfunction

    function void check_frame(stick_frame_t got);
      stick_frame_t want;
      results_seen++;
      if (owed_sticks.size() == 0) begin
        if (mismatches < 10)
          $display("Stick frame %0d arrived with nothing pending: roll %0d pitch %0d",
                   results_seen, $signed(got.roll), $signed(got.pitch));
        mismatches++;
        return;
      end
      want = owed_sticks.pop_front();
      compare("roll_norm", $signed(want.roll), $signed(got.roll));
      compare("pitch_norm", $signed(want.pitch), $signed(got.pitch));
      compare("throttle_norm", int'(want.throttle), int'(got.throttle));
      compare("yaw_norm", $signed(want.yaw), $signed(got.yaw));
    endfunction
  endclass

  logic clk;
  logic rst;
  int   frames_sent = 0;
  int   settings_run = 0;
  bit   no_gaps = 1'b0;

  stick_scoreboard sb = new();

  rcsn_pulse_if pulses();
  rcsn_norm_if  sticks();
  rcsn_cfg_if   cfg();

  rc_stick_normalizer dut (
    .clk    (clk),
    .rst    (rst),
    .pulses (pulses),
    .sticks (sticks),
    .cfg    (cfg)
  );

  // Edge cases: pulse extremes, plausibility limits, centre, deadband edges
  // for the reset deadband, throttle below its base and both clamp regions.
  localparam pulse_frame_t EDGE_FRAMES [12] = '{
    '{16'd0,     16'd0,     16'd0,     16'd0},
    '{16'd65535, 16'd65535, 16'd65535, 16'd65535},
    '{16'd899,   16'd2101,  16'd899,   16'd2101},
    '{16'd900,   16'd2100,  16'd900,   16'd2100},
    '{16'd1500,  16'd1500,  16'd1500,  16'd1500},
    '{16'd1490,  16'd1510,  16'd999,   16'd1489},
    '{16'd1511,  16'd1000,  16'd1000,  16'd2000},
    '{16'd2001,  16'd999,   16'd2000,  16'd1999},
    '{16'd1501,  16'd1499,  16'd2001,  16'd1250},
    '{16'd32768, 16'd1750,  16'd1001,  16'd901},
    '{16'd1300,  16'd1700,  16'd1500,  16'd2099},
    '{16'd901,   16'd1200,  16'd1800,  16'd1600}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly no gap, some short ones and the odd long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Pulses cluster on the interesting points: deadband edges, limits, and clamp knees.
  function automatic logic [PULSE_W-1:0] pick_pulse(bit is_throttle);
    int r;
    int db;
    r  = $urandom_range(0, 99);
    db = sb.deadband;
    if (r < 55)
      return $urandom_range(int'(PULSE_MIN), int'(PULSE_MAX));
    if (r < 70) begin
      if (is_throttle)
        return int'(THR_BASE) + $urandom_range(0, 10) - 5;
      if ($urandom_range(0, 1))
        return int'(STICK_CENTRE) + db + $urandom_range(0, 2) - 1;
      return int'(STICK_CENTRE) - db + $urandom_range(0, 2) - 1;
    end
    if (r < 85) begin
      case ($urandom_range(0, 5))
        0: return int'(PULSE_MIN) - $urandom_range(0, 1);
        1: return int'(PULSE_MAX) + $urandom_range(0, 1);
        2: return int'(STICK_CENTRE) - STICK_SPAN_US + $urandom_range(0, 2) - 1;
        3: return int'(STICK_CENTRE) + STICK_SPAN_US + $urandom_range(0, 2) - 1;
        4: return int'(THR_BASE) + THR_SPAN_US + $urandom_range(0, 2) - 1;
        default: return int'(STICK_CENTRE);
      endcase
    end
    return $urandom_range(0, 65535);
  endfunction

  function automatic pulse_frame_t random_frame();
    pulse_frame_t f;
    f.roll     = pick_pulse(1'b0);
    f.pitch    = pick_pulse(1'b0);
    f.throttle = pick_pulse(1'b1);
    f.yaw      = pick_pulse(1'b0);
    return f;
  endfunction

  // Watch all three channels at the clock edge.
  always @(posedge clk) begin
    stick_frame_t got;
    if (!rst) begin
      if (cfg.valid && cfg.ready)
        sb.write_reg(cfg.index, cfg.data);
      if (pulses.valid && pulses.ready)
        sb.note_frame('{pulses.roll_pulse, pulses.pitch_pulse,
                        pulses.throttle_pulse, pulses.yaw_pulse});
      if (sticks.valid && sticks.ready) begin
        got.roll     = sticks.roll_norm;
        got.pitch    = sticks.pitch_norm;
        got.throttle = sticks.throttle_norm;
        got.yaw      = sticks.yaw_norm;
        sb.check_frame(got);
      end
    end
  end

  // Receiver back-pressure: random stalls, with occasional long stretches of ready.
  initial begin
    int stall;
    int run;
    sticks.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = idle_len();
      if (stall > 0) begin
        sticks.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      sticks.ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
      repeat (run) @(posedge clk);
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= index;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Valid stays high between back-to-back requests; it only drops ahead of a gap.
  task automatic send_frame(input pulse_frame_t f);
    int gap;
    gap = no_gaps ? 0 : idle_len();
    if (gap > 0) begin
      pulses.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pulses.valid          <= 1'b1;
    pulses.roll_pulse     <= f.roll;
    pulses.pitch_pulse    <= f.pitch;
    pulses.throttle_pulse <= f.throttle;
    pulses.yaw_pulse      <= f.yaw;
    do @(posedge clk); while (!pulses.ready);
    frames_sent++;
  endtask

  // Wait until every frame sent has come back, then let the pipeline empty.
  task automatic drain_pipeline();
    while (sb.results_seen < frames_sent) @(posedge clk);
    repeat (NUM_STAGES + 3) @(posedge clk);
  endtask

  task automatic apply_settings(input int db, input bit shape);
    write_reg(CFG_DEADBAND_US, db[CFG_DATA_W-1:0]);
    write_reg(CFG_SHAPE_MODE, {8'($urandom_range(0, 255)), shape});
    // Writes to unused indexes must leave both registers alone.
    if ($urandom_range(0, 1))
      write_reg($urandom_range(int'(CFG_SHAPE_MODE) + 1, (1 << CFG_INDEX_W) - 1),
                $urandom_range(0, (1 << CFG_DATA_W) - 1));
    settings_run++;
  endtask

  task automatic send_edge_frames();
    foreach (EDGE_FRAMES[i])
      send_frame(EDGE_FRAMES[i]);
    pulses.valid <= 1'b0;
  endtask

  initial begin
    int db;
    bit shape;
    int leftover;
    rst                   <= 1'b1;
    pulses.valid          <= 1'b0;
    pulses.roll_pulse     <= '0;
    pulses.pitch_pulse    <= '0;
    pulses.throttle_pulse <= '0;
    pulses.yaw_pulse      <= '0;
    cfg.valid             <= 1'b0;
    cfg.index             <= CFG_DEADBAND_US;
    cfg.data              <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Edge cases at reset settings, then again linear with no deadband.
    settings_run = 1;
    send_edge_frames();
    drain_pipeline();
    apply_settings(0, 1'b0);
    send_edge_frames();
    drain_pipeline();

    // Random frames over a spread of settings, extremes included.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin db = 0;   shape = 1'b1; end
        1: begin db = 500; shape = 1'b0; end
        2: begin db = 511; shape = 1'b1; end
        3: begin db = 1;   shape = 1'b0; end
        7: begin db = 500; shape = 1'b1; end
        default: begin
          db    = $urandom_range(0, (1 << DEADBAND_W) - 1);
          shape = $urandom_range(0, 1);
        end
      endcase
      apply_settings(db, shape);
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (PHASE_FRAMES)
        send_frame(random_frame());
      pulses.valid <= 1'b0;
      drain_pipeline();
    end

    leftover = sb.owed_sticks.size();
    if (leftover != 0)
      $display("%0d stick frames were never returned", leftover);
    $display("Sent %0d pulse frames under %0d register settings, checked %0d stick frames.",
             frames_sent, settings_run, sb.results_seen);
    $display("Deadband ran from 0 to 511 in linear and cubic shaping; %0d field mismatches.",
             sb.mismatches);
    if (sb.mismatches == 0 && leftover == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #20_000_000;
    $display("Run stopped: the block stopped answering");
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ===== rc_stick_normalizer.f =====
hdl/rcsn_pkg.sv
hdl/rcsn_if.sv
hdl/rcsn_stick_lane.sv
hdl/rcsn_thr_lane.sv
hdl/rc_stick_normalizer.sv
tb/tb_top.sv
